/* rtl/rgbfb_pkg.sv */
// rgbfb_pkg: shared types and constants of the rgb565 framebuffer port
// command and result beat structs, result kind codes, field widths
// no dependencies
package rgbfb_pkg;

  localparam int ADDR_W  = 20;
  localparam int DATA_W  = 32;
  localparam int COORD_W = 9;
  localparam int PIX_W   = 19;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] byte_address;
    logic [DATA_W-1:0] write_data;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [DATA_W-1:0]  read_data;
    logic               was_written;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               last;
  } res_t;

endpackage

/* rtl/rgbfb_ram.sv */
// rgbfb_ram: generic simple dual-port synchronous ram
// one write port, one read port with registered read data
// no dependencies
module rgbfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/rgb565_framebuffer_port_core.sv */
// rgb565_framebuffer_port_core: rgb565 framebuffer with word access and pixel updates
// depends on rgbfb_pkg and rgbfb_ram
// frame words live in one rgbfb_ram, read-compare-write sequenced here
//
// After reset the block holds busy high while it clears the frame memory, one word per
// cycle, all SCREEN_WIDTH*SCREEN_HEIGHT/2 words (76800 at 480x320). A command is taken
// when start is high and busy is low. A read gives one result; a write that is out of
// range or leaves the word unchanged gives one write-done result; a performed write
// gives two pixel updates and a write-done result on consecutive cycles. The single
// memory access (read, compare, write back in the cycle after the command) and the two
// registered multiplies that turn the pixel index into row and column set the states:
// a read or an unperformed write passes S_LOOK only, a performed write S_LOOK, S_MUL,
// S_PIX0, S_PIX1 and S_DONE. Each result shows on result for one cycle with strobe high;
// the receiver cannot hold it off, and last marks the final result of a command.
module rgb565_framebuffer_port_core
  import rgbfb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 320
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t command,
  output logic strobe,
  output res_t result
);

  localparam int FB_WORDS = (SCREEN_WIDTH * SCREEN_HEIGHT) / 2;
  localparam int AW       = FB_WORDS > 1 ? $clog2(FB_WORDS) : 1;
  localparam int XW       = $clog2(SCREEN_WIDTH);
  localparam int RW       = $clog2(2 * SCREEN_WIDTH);
  localparam logic [31:0] RECIP = 32'((64'd1 << 31) / SCREEN_WIDTH);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_LOOK  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_PIX0  = 7'b0010000,
    S_PIX1  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t            st, st_next;
  logic [AW-1:0]     clr_addr;
  logic              act;
  logic              in_rng;
  logic [AW-1:0]     idx;
  logic [DATA_W-1:0] wdat;
  logic [PIX_W-1:0]  pix;
  logic [PIX_W-1:0]  q_est;
  logic [RW-1:0]     rem_raw;
  logic [XW-1:0]     x1;
  logic [PIX_W-1:0]  y1;
  logic              strobe_next;
  res_t              res_next;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic [PIX_W+31:0] prod;
  logic [31:0]       qw;
  logic [31:0]       diff;
  logic              wr_go;
  logic              rem_big;
  logic [XW-1:0]     x0;
  logic [PIX_W-1:0]  y0;
  logic              x0_end;
  logic [17:0]       cmd_idx;

  assign busy    = (st != S_IDLE);
  assign cmd_idx = command.byte_address[ADDR_W-1:2];

  rgbfb_ram #(
    .WIDTH(DATA_W),
    .DEPTH(FB_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ram_raddr = AW'(cmd_idx);
  assign ram_waddr = (st == S_CLEAR) ? clr_addr : idx;
  assign ram_wdata = (st == S_CLEAR) ? '0 : wdat;
  assign wr_go     = act && in_rng && (ram_rdata != wdat);
  assign ram_we    = (st == S_CLEAR) || ((st == S_LOOK) && wr_go);

  assign prod    = (PIX_W + 32)'(pix) * (PIX_W + 32)'(RECIP);
  assign qw      = 32'(q_est) * 32'(SCREEN_WIDTH);
  assign diff    = 32'(pix) - qw;
  assign rem_big = (32'(rem_raw) >= 32'(SCREEN_WIDTH));
  assign x0      = rem_big ? XW'(rem_raw - RW'(SCREEN_WIDTH)) : XW'(rem_raw);
  assign y0      = rem_big ? q_est + PIX_W'(1) : q_est;
  assign x0_end  = (x0 == XW'(SCREEN_WIDTH - 1));

  function automatic res_t pixel_beat(input logic [15:0] p, input logic [XW-1:0] x,
                                      input logic [PIX_W-1:0] y);
    res_t r;
    r             = '0;
    r.result_kind = KIND_PIXEL;
    r.pixel_x     = COORD_W'(x);
    r.pixel_y     = y[COORD_W-1:0];
    r.red         = {p[15:11], 3'b000};
    r.green       = {p[10:5], 2'b00};
    r.blue        = {p[4:0], 3'b000};
    return r;
  endfunction

  always_comb begin
    st_next     = st;
    strobe_next = 1'b0;
    res_next    = '0;
    case (st)
      S_CLEAR: begin
        if (clr_addr == AW'(FB_WORDS - 1)) begin
          st_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          st_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!act) begin
          strobe_next          = 1'b1;
          res_next.result_kind = KIND_READ;
          res_next.read_data   = in_rng ? ram_rdata : '0;
          res_next.last        = 1'b1;
          st_next              = S_IDLE;
        end else if (!wr_go) begin
          strobe_next          = 1'b1;
          res_next.result_kind = KIND_DONE;
          res_next.last        = 1'b1;
          st_next              = S_IDLE;
        end else begin
          st_next = S_MUL;
        end
      end
      S_MUL: begin
        st_next = S_PIX0;
      end
      S_PIX0: begin
        strobe_next = 1'b1;
        res_next    = pixel_beat({wdat[7:0], wdat[15:8]}, x0, y0);
        st_next     = S_PIX1;
      end
      S_PIX1: begin
        strobe_next = 1'b1;
        res_next    = pixel_beat({wdat[23:16], wdat[31:24]}, x1, y1);
        st_next     = S_DONE;
      end
      S_DONE: begin
        strobe_next          = 1'b1;
        res_next.result_kind = KIND_DONE;
        res_next.was_written = 1'b1;
        res_next.last        = 1'b1;
        st_next              = S_IDLE;
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_CLEAR;
      clr_addr <= '0;
      strobe   <= 1'b0;
    end else begin
      st     <= st_next;
      strobe <= strobe_next;
      if (st == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    result <= res_next;
    if (st == S_IDLE && start) begin
      act    <= command.action;
      in_rng <= (32'(cmd_idx) < 32'(FB_WORDS));
      idx    <= AW'(cmd_idx);
      wdat   <= command.write_data;
      pix    <= {cmd_idx, 1'b0};
    end
    if (st == S_LOOK) begin
      q_est <= prod[PIX_W+30:31];
    end
    if (st == S_MUL) begin
      rem_raw <= diff[RW-1:0];
    end
    if (st == S_PIX0) begin
      x1 <= x0_end ? '0 : x0 + XW'(1);
      y1 <= x0_end ? y0 + PIX_W'(1) : y0;
    end
  end

endmodule

/* rtl/rgbfb_checker.sv */
// rgbfb_checker: port-level checks of the rgb565 framebuffer port
// depends on rgbfb_pkg, bound to rgb565_framebuffer_port_core
module rgbfb_checker
  import rgbfb_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input res_t result
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low right after a command was taken");

  a_pixel_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && result.result_kind == KIND_PIXEL |-> !result.last)
    else $error("pixel update beat marked last");

  a_pixel_follow: assert property (@(posedge clk) disable iff (rst)
    strobe && result.result_kind == KIND_PIXEL |=> strobe)
    else $error("pixel update beat not followed by another beat");

  a_written_after_pixel: assert property (@(posedge clk) disable iff (rst)
    strobe && result.result_kind == KIND_DONE && result.was_written
      |-> $past(strobe) && $past(result.result_kind) == KIND_PIXEL)
    else $error("performed write done without preceding pixel update");

endmodule

bind rgb565_framebuffer_port_core rgbfb_checker u_rgbfb_checker (.*);
